>>> rtl/ost_pkg.sv
// Shared types and codes for the ordered sequence table.
`default_nettype none

package ost_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT_AT      = 3'd0,
    CMD_ORDERED_INSERT = 3'd1,
    CMD_ERASE          = 3'd2,
    CMD_REMOVE_ALL     = 3'd3,
    CMD_GET            = 3'd4,
    CMD_SET            = 3'd5,
    CMD_FIND           = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture a command and compare it against all cells.
    logic step;    // Close the gap at the first matching cell.
    logic finish;  // Apply the command and load the result register.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;  // The held command is remove all.
    logic any_match;  // Some live cell still equals the held item.
    logic res_free;   // The result register can take a new result.
  } ctrl_stat_t;

endpackage

`default_nettype wire

>>> rtl/ordered_sequence_table.sv
// Top level of the ordered sequence table: controller plus cell datapath.
`default_nettype none

// The table keeps an ordered list of up to CAPACITY unsigned items in a row
// of register cells and takes one command per input transfer: insert at a
// position, ordered insert, erase, remove all copies of a value, get, set or
// find. Every command returns exactly one result transfer carrying a status,
// an index, the item read by get, the number of entries removed and the fill
// count after the command. A command goes from its input transfer to its
// result through an accept step and an execute step: the accept step
// compares the new item against every cell in parallel and registers the
// match and order flags, and the execute step shifts the cells and loads the
// result register. Remove all stays in the execute step while matches remain,
// since the compaction closes one gap per cycle. The next command is
// taken as soon as the previous one has been written to the result register,
// even while that result still waits for its output transfer; a result held
// back by the consumer delays only the execute cycle of the following command.
// Positions beyond the current size are rejected with status one, and inserts
// into a full table report status two without changing the list.

module ordered_sequence_table #(
  parameter int CAPACITY  = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           command_i,
  input  logic [4:0]           position_i,
  input  logic [ITEM_BITS-1:0] item_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [4:0]           index_out_o,
  output logic [ITEM_BITS-1:0] item_out_o,
  output logic [4:0]           removed_count_o,
  output logic [4:0]           fill_count_o
);

  // Command and status groups between the controller and the datapath.
  ost_pkg::ctrl_cmd_t  ctrl_cmd;
  ost_pkg::ctrl_stat_t ctrl_stat;

  // The controller accepts a command only while idle and then holds the
  // datapath in its execute step until the command and its result are done.
  ost_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (ctrl_stat),
    .cmd_o      (ctrl_cmd)
  );

  // The datapath owns the cells, the entry count and the result register.
  ost_datapath #(
    .CAPACITY  (CAPACITY),
    .ITEM_BITS (ITEM_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .stat_o          (ctrl_stat),
    .command_i       (command_i),
    .position_i      (position_i),
    .item_in_i       (item_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .index_out_o     (index_out_o),
    .item_out_o      (item_out_o),
    .removed_count_o (removed_count_o),
    .fill_count_o    (fill_count_o)
  );

endmodule

`default_nettype wire

>>> rtl/ost_ctrl.sv
// Controller state machine that sequences each command through the datapath.
`default_nettype none

module ost_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ost_pkg::ctrl_stat_t stat_i,
  output ost_pkg::ctrl_cmd_t  cmd_o
);

  ost_pkg::state_e state_q, state_d;
  logic            compacting;

  assign compacting = stat_i.is_remove & stat_i.any_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ost_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ost_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ost_pkg::ST_EXEC;
        end
      end
      ost_pkg::ST_EXEC: begin
        if (!compacting && stat_i.res_free) begin
          state_d = ost_pkg::ST_IDLE;
        end
      end
      default: state_d = ost_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ost_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ost_pkg::ST_EXEC: begin
        cmd_o.step   = compacting;
        cmd_o.finish = !compacting && stat_i.res_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ost_datapath.sv
// Cell array, compare flags, entry count and result register of the table.
`default_nettype none

module ost_datapath #(
  parameter int CAPACITY  = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ost_pkg::ctrl_cmd_t   cmd_i,
  output ost_pkg::ctrl_stat_t  stat_o,
  input  logic [2:0]           command_i,
  input  logic [4:0]           position_i,
  input  logic [ITEM_BITS-1:0] item_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [4:0]           index_out_o,
  output logic [ITEM_BITS-1:0] item_out_o,
  output logic [4:0]           removed_count_o,
  output logic [4:0]           fill_count_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // Index of the lowest set bit of a flag vector.
  function automatic logic [IDX_W-1:0] first_idx(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] r;
    logic             seen;
    r    = '0;
    seen = 1'b0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (v[j] && !seen) begin
        r = IDX_W'(j);
      end
      seen = seen | v[j];
    end
    return r;
  endfunction

  // Cells hold no reset: only positions below the count are ever read.
  logic [ITEM_BITS-1:0] cells_q [CAPACITY];
  logic [ITEM_BITS-1:0] cells_d [CAPACITY];
  logic [CAPACITY-1:0]  match_q, match_d;
  logic [CAPACITY-1:0]  nl_q, nl_d;
  logic [CAPACITY-1:0]  ge_mask;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     removed_q, removed_d;
  ost_pkg::cmd_e        cmd_q;
  logic [4:0]           pos_q;
  logic [ITEM_BITS-1:0] item_q;

  logic                 out_valid_q;
  ost_pkg::status_e     status_q;
  logic [4:0]           index_q;
  logic [ITEM_BITS-1:0] item_out_q;
  logic [4:0]           removed_out_q;
  logic [4:0]           fill_q;

  logic [CMP_W-1:0]     cnt_ext, pos_ext, res_index, removed_ext, new_cnt_ext;
  logic [IDX_W-1:0]     match_idx, nl_idx, pos_idx, ins_at;
  ost_pkg::status_e     res_status;
  logic [ITEM_BITS-1:0] res_item;
  logic                 ins_en, del_en, set_en, is_full;

  assign cnt_ext     = CMP_W'(count_q);
  assign pos_ext     = CMP_W'(pos_q);
  assign pos_idx     = pos_ext[IDX_W-1:0];
  assign match_idx   = first_idx(match_q);
  assign nl_idx      = first_idx(nl_q);
  assign is_full     = (cnt_ext == CMP_W'(CAPACITY));
  assign removed_ext = CMP_W'(removed_q);
  assign new_cnt_ext = CMP_W'(count_d);

  always_comb begin
    ge_mask[0] = match_q[0];
    for (int j = 1; j < CAPACITY; j++) begin
      ge_mask[j] = ge_mask[j-1] | match_q[j];
    end
  end

  // Decode of the held command against the current table.
  always_comb begin
    res_status = ost_pkg::STAT_OK;
    res_index  = '0;
    res_item   = '0;
    ins_en     = 1'b0;
    ins_at     = '0;
    del_en     = 1'b0;
    set_en     = 1'b0;
    case (cmd_q)
      ost_pkg::CMD_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          res_status = ost_pkg::STAT_BAD_POS;
        end else if (is_full) begin
          res_status = ost_pkg::STAT_FULL;
        end else begin
          ins_en    = 1'b1;
          ins_at    = pos_idx;
          res_index = pos_ext;
        end
      end
      ost_pkg::CMD_ORDERED_INSERT: begin
        if (is_full) begin
          res_status = ost_pkg::STAT_FULL;
        end else begin
          ins_en    = 1'b1;
          ins_at    = (|nl_q) ? nl_idx : count_q[IDX_W-1:0];
          res_index = CMP_W'(ins_at);
        end
      end
      ost_pkg::CMD_ERASE: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ost_pkg::STAT_BAD_POS;
        end else begin
          del_en = 1'b1;
        end
      end
      ost_pkg::CMD_REMOVE_ALL: ;
      ost_pkg::CMD_GET: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ost_pkg::STAT_BAD_POS;
        end else begin
          res_item = cells_q[pos_idx];
        end
      end
      ost_pkg::CMD_SET: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ost_pkg::STAT_BAD_POS;
        end else begin
          set_en = 1'b1;
        end
      end
      ost_pkg::CMD_FIND: begin
        if (|match_q) begin
          res_index = CMP_W'(match_idx);
        end else begin
          res_status = ost_pkg::STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // Next values of cells, flags and counters.
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cells_d[j] = cells_q[j];
    end
    match_d   = match_q;
    nl_d      = nl_q;
    count_d   = count_q;
    removed_d = removed_q;

    if (cmd_i.load) begin
      removed_d = '0;
      for (int j = 0; j < CAPACITY; j++) begin
        match_d[j] = (CNT_W'(j) < count_q) && (cells_q[j] == item_in_i);
        nl_d[j]    = (CNT_W'(j) < count_q) && !(cells_q[j] < item_in_i);
      end
    end

    if (cmd_i.step) begin
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (ge_mask[j]) begin
          cells_d[j] = cells_q[j+1];
          match_d[j] = match_q[j+1];
        end
      end
      match_d[CAPACITY-1] = 1'b0;
      count_d   = count_q - CNT_W'(1);
      removed_d = removed_q + CNT_W'(1);
    end

    if (cmd_i.finish) begin
      if (ins_en) begin
        if (ins_at == '0) begin
          cells_d[0] = item_q;
        end
        for (int j = 1; j < CAPACITY; j++) begin
          if (IDX_W'(j) == ins_at) begin
            cells_d[j] = item_q;
          end else if (IDX_W'(j) > ins_at) begin
            cells_d[j] = cells_q[j-1];
          end
        end
        count_d = count_q + CNT_W'(1);
      end
      if (del_en) begin
        for (int j = 0; j < CAPACITY - 1; j++) begin
          if (IDX_W'(j) >= pos_idx) begin
            cells_d[j] = cells_q[j+1];
          end
        end
        count_d = count_q - CNT_W'(1);
      end
      if (set_en) begin
        for (int j = 0; j < CAPACITY; j++) begin
          if (IDX_W'(j) == pos_idx) begin
            cells_d[j] = item_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < CAPACITY; j++) begin
      cells_q[j] <= cells_d[j];
    end
    match_q   <= match_d;
    nl_q      <= nl_d;
    removed_q <= removed_d;
    if (cmd_i.load) begin
      cmd_q  <= ost_pkg::cmd_e'(command_i);
      pos_q  <= position_i;
      item_q <= item_in_i;
    end
    if (cmd_i.finish) begin
      status_q      <= res_status;
      index_q       <= res_index[4:0];
      item_out_q    <= res_item;
      removed_out_q <= (cmd_q == ost_pkg::CMD_REMOVE_ALL) ? removed_ext[4:0] : 5'd0;
      fill_q        <= new_cnt_ext[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.is_remove = (cmd_q == ost_pkg::CMD_REMOVE_ALL);
  assign stat_o.any_match = |match_q;
  assign stat_o.res_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign index_out_o     = index_q;
  assign item_out_o      = item_out_q;
  assign removed_count_o = removed_out_q;
  assign fill_count_o    = fill_q;

endmodule

`default_nettype wire

>>> rtl/ost_checker.sv
// Port-level checks of the ordered sequence table and their bind.
`default_nettype none

module ost_checker #(
  parameter int CAPACITY  = 16,
  parameter int ITEM_BITS = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [1:0]           status_o,
  input logic [4:0]           index_out_o,
  input logic [ITEM_BITS-1:0] item_out_o,
  input logic [4:0]           removed_count_o,
  input logic [4:0]           fill_count_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(index_out_o) && $stable(item_out_o) && $stable(fill_count_o))
    else $error("result changed while stalled");

  // An accepted command closes the input side in the cycle after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted during execution");

  // A failed command reports no index, item or removal count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ost_pkg::STAT_OK) |->
      index_out_o == 5'd0 && item_out_o == '0 && removed_count_o == 5'd0)
    else $error("failed command carries data");

  // The fill count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 31) || (int'(fill_count_o) <= CAPACITY))
    else $error("fill count beyond capacity");

  // Entries removed never exceed the capacity either.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 31) || (int'(removed_count_o) <= CAPACITY))
    else $error("removed count beyond capacity");

endmodule

bind ordered_sequence_table ost_checker #(
  .CAPACITY  (CAPACITY),
  .ITEM_BITS (ITEM_BITS)
) u_ost_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .index_out_o     (index_out_o),
  .item_out_o      (item_out_o),
  .removed_count_o (removed_count_o),
  .fill_count_o    (fill_count_o)
);

`default_nettype wire

>>> verif/ost_checker.sv
// Result checker for the ordered sequence table: predicts each command and compares every result.
module ost_result_checker #(
  parameter int CAPACITY  = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [2:0]           command_i,
  input  logic [4:0]           position_i,
  input  logic [ITEM_BITS-1:0] item_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           status_i,
  input  logic [4:0]           index_out_i,
  input  logic [ITEM_BITS-1:0] item_out_i,
  input  logic [4:0]           removed_count_i,
  input  logic [4:0]           fill_count_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ost_pkg::status_e     status;
    logic [4:0]           index;
    logic [ITEM_BITS-1:0] item;
    logic [4:0]           removed;
    logic [4:0]           fill;
  } table_result_t;

  // Shadow copy of the list; only entries below list_len are ever read.
  logic [ITEM_BITS-1:0] list_q [CAPACITY];
  int                   list_len = 0;
  table_result_t        expected_q [$];
  int                   failures = 0;

  function automatic void open_gap(int at, logic [ITEM_BITS-1:0] item);
    for (int k = list_len; k > at; k--) begin
      list_q[k] = list_q[k-1];
    end
    list_q[at] = item;
    list_len++;
  endfunction

  // Applies one command to the shadow list and returns the result it must produce.
  function automatic table_result_t apply_command(logic [2:0] cmd, logic [4:0] pos,
                                                  logic [ITEM_BITS-1:0] item);
    table_result_t r;
    int            k;
    int            w;
    r = '0;
    r.status = ost_pkg::STAT_OK;
    case (cmd)
      ost_pkg::CMD_INSERT_AT: begin
        if (pos > list_len) begin
          r.status = ost_pkg::STAT_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          r.status = ost_pkg::STAT_FULL;
        end else begin
          open_gap(pos, item);
          r.index = pos;
        end
      end
      ost_pkg::CMD_ORDERED_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ost_pkg::STAT_FULL;
        end else begin
          k = 0;
          while (k < list_len && list_q[k] < item) k++;
          open_gap(k, item);
          r.index = 5'(k);
        end
      end
      ost_pkg::CMD_ERASE: begin
        if (pos >= list_len) begin
          r.status = ost_pkg::STAT_BAD_POS;
        end else begin
          for (k = pos; k + 1 < list_len; k++) begin
            list_q[k] = list_q[k+1];
          end
          list_len--;
        end
      end
      ost_pkg::CMD_REMOVE_ALL: begin
        w = 0;
        for (k = 0; k < list_len; k++) begin
          if (list_q[k] == item) begin
            r.removed++;
          end else begin
            list_q[w] = list_q[k];
            w++;
          end
        end
        list_len = w;
      end
      ost_pkg::CMD_GET: begin
        if (pos >= list_len) r.status = ost_pkg::STAT_BAD_POS;
        else r.item = list_q[pos];
      end
      ost_pkg::CMD_SET: begin
        if (pos >= list_len) r.status = ost_pkg::STAT_BAD_POS;
        else list_q[pos] = item;
      end
      ost_pkg::CMD_FIND: begin
        r.status = ost_pkg::STAT_NOT_FOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_q[k] == item) begin
            r.status = ost_pkg::STAT_OK;
            r.index  = 5'(k);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.fill = 5'(list_len);
    return r;
  endfunction

  always @(posedge clk_i) begin
    table_result_t seen;
    table_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      expected_q.delete();
      failures = 0;
    end else begin
      // Results are retired before new commands are predicted, so a result
      // can never be matched against a command accepted on the same edge.
      if (out_valid_i && out_ready_i) begin
        seen.status  = ost_pkg::status_e'(status_i);
        seen.index   = index_out_i;
        seen.item    = item_out_i;
        seen.removed = removed_count_i;
        seen.fill    = fill_count_i;
        if (expected_q.size() == 0) begin
          if (failures < 10) begin
            $display("%0t: result with nothing outstanding: status %0d index %0d item %h",
                     $realtime, seen.status, seen.index, seen.item);
          end
          failures++;
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            if (failures < 10) begin
              $display("%0t: mismatch status %0d/%0d index %0d/%0d item %h/%h",
                       $realtime, want.status, seen.status, want.index, seen.index,
                       want.item, seen.item);
              $display("  removed %0d/%0d fill %0d/%0d (expected/actual)",
                       want.removed, seen.removed, want.fill, seen.fill);
            end
            failures++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(apply_command(command_i, position_i, item_in_i));
      end
    end
    pending_o    <= expected_q.size();
    fail_count_o <= failures;
  end

endmodule

>>> verif/ordered_sequence_table_test.sv
// Top of the ordered sequence table test: clock, reset, stimulus, flow control and verdict.
module ordered_sequence_table_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY  = 16;
  localparam int ITEM_BITS = 32;

  // Command code 7 has no meaning; the block must answer it without touching the list.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Length of the long receiver stall used to back the block up.
  localparam int HOLD_CYCLES = 400;
  // Cycles allowed after the last result for stray output to show up. The
  // slowest command is remove all on a full table.
  localparam int SETTLE_CYCLES = 40;
  // Watchdog. It leaves a wide margin over what a correct run needs, even
  // with heavy idling on both sides.
  localparam int CYCLE_LIMIT = 200_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [2:0]           command_i = ost_pkg::CMD_GET;
  logic [4:0]           position_i = '0;
  logic [ITEM_BITS-1:0] item_in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           status_o;
  logic [4:0]           index_out_o;
  logic [ITEM_BITS-1:0] item_out_o;
  logic [4:0]           removed_count_o;
  logic [4:0]           fill_count_o;

  int fail_count;
  int pending;

  // Idle rates in percent. The sender rate is used only by the stimulus
  // process; the receiver rate is changed with nonblocking writes so the
  // receiver process never races the stimulus for it.
  int send_idle_pct = 12;
  int recv_idle_pct = 56;

  // A one-cycle pulse from the stimulus starts a long receiver stall.
  logic hold_off_req = 1'b0;
  int   hold_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ordered_sequence_table #(
    .CAPACITY  (CAPACITY),
    .ITEM_BITS (ITEM_BITS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .item_in_i       (item_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .index_out_o     (index_out_o),
    .item_out_o      (item_out_o),
    .removed_count_o (removed_count_o),
    .fill_count_o    (fill_count_o)
  );

  ost_result_checker #(
    .CAPACITY  (CAPACITY),
    .ITEM_BITS (ITEM_BITS)
  ) table_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .item_in_i       (item_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .index_out_i     (index_out_o),
    .item_out_i      (item_out_o),
    .removed_count_i (removed_count_o),
    .fill_count_i    (fill_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Receiver side. Ready is redrawn every cycle from the current idle rate,
  // except during a requested stall, which this process counts down itself.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_off_req) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one command and returns at the edge where it is transferred. The
  // random gap comes first with valid low; once valid rises it stays up with
  // the payload frozen until the block takes it. Valid is left high on
  // return, so the caller either sends again or lowers it before waiting.
  task automatic send_command(input logic [2:0] cmd, input logic [4:0] pos,
                              input logic [ITEM_BITS-1:0] item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    item_in_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering and waits until every predicted result has been
  // transferred. The checker publishes its count with a nonblocking write, so
  // the task waits on the clock before its first read.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Item values lean heavily on a small pool so that find, remove all and
  // ordered insert see duplicates and real matches; the extremes and fully
  // random words keep every bit of the field moving.
  function automatic logic [ITEM_BITS-1:0] random_item();
    case ($urandom_range(9))
      0:       return '1;
      1:       return {1'b1, {(ITEM_BITS-1){1'b0}}};
      2, 3:    return ITEM_BITS'($urandom);
      default: return ITEM_BITS'($urandom_range(6));
    endcase
  endfunction

  // Mostly small positions, which are valid for most fill levels, with
  // positions up to 16 mixed in to hit the out-of-range checks.
  function automatic logic [4:0] random_position();
    if ($urandom_range(2) == 0) return 5'($urandom_range(16));
    return 5'($urandom_range(5));
  endfunction

  // The command mix alternates between a growing bias, which drives the list
  // to full and keeps it there for a while, and a shrinking bias, which
  // drains it again through erase and remove all.
  function automatic logic [2:0] random_command(bit grow);
    int roll;
    roll = $urandom_range(99);
    if (grow) begin
      if (roll < 30) return ost_pkg::CMD_INSERT_AT;
      if (roll < 60) return ost_pkg::CMD_ORDERED_INSERT;
      if (roll < 66) return ost_pkg::CMD_ERASE;
      if (roll < 70) return ost_pkg::CMD_REMOVE_ALL;
    end else begin
      if (roll < 8)  return ost_pkg::CMD_INSERT_AT;
      if (roll < 16) return ost_pkg::CMD_ORDERED_INSERT;
      if (roll < 46) return ost_pkg::CMD_ERASE;
      if (roll < 60) return ost_pkg::CMD_REMOVE_ALL;
    end
    if (roll < 80) return ost_pkg::CMD_GET;
    if (roll < 88) return ost_pkg::CMD_SET;
    if (roll < 98) return ost_pkg::CMD_FIND;
    return CMD_UNUSED;
  endfunction

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit grow;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the empty list. Every access by position
    // is out of range here, insert at one past the end is rejected, remove
    // all with no match reports zero, and the unused code changes nothing.
    send_command(ost_pkg::CMD_GET, 5'd0, '0);
    send_command(ost_pkg::CMD_ERASE, 5'd0, '0);
    send_command(ost_pkg::CMD_SET, 5'd0, 32'h1234_5678);
    send_command(ost_pkg::CMD_INSERT_AT, 5'd1, 32'd9);
    send_command(ost_pkg::CMD_REMOVE_ALL, 5'd0, 32'd3);
    send_command(CMD_UNUSED, 5'd31, '1);

    // Build up to a full list: insert at the front, then at the end, then
    // ordered inserts that include duplicates of values already present.
    send_command(ost_pkg::CMD_INSERT_AT, 5'd0, '1);
    send_command(ost_pkg::CMD_INSERT_AT, 5'd0, '0);
    send_command(ost_pkg::CMD_INSERT_AT, 5'd2, 32'h8000_0000);
    for (int k = 0; k < CAPACITY - 3; k++) begin
      send_command(ost_pkg::CMD_ORDERED_INSERT, '0, ITEM_BITS'((k * 5) % 7));
    end

    // Full table: both insert kinds are refused, a position equal to the
    // size is out of range for get, a missing value is not found, and remove
    // all compacts out every zero.
    send_command(ost_pkg::CMD_INSERT_AT, 5'd16, 32'd2);
    send_command(ost_pkg::CMD_ORDERED_INSERT, '0, 32'd2);
    send_command(ost_pkg::CMD_GET, 5'd16, '0);
    send_command(ost_pkg::CMD_FIND, '0, 32'd9);
    send_command(ost_pkg::CMD_REMOVE_ALL, '0, 32'd0);

    // The sender pauses here until every outstanding result is back.
    wait_for_results();

    // Three random phases of about 400 commands: sender idles lightly while
    // the receiver idles heavily, then the reverse, then neither idles.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct <= 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct <= 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int i = 0; i < 400; i++) begin
        // Halfway through the last phase the receiver stalls for a long
        // stretch while commands keep coming, so the result register fills
        // and the block has to hold its input off.
        if (phase == 2 && i == 200) begin
          in_valid_i   <= 1'b0;
          hold_off_req <= 1'b1;
          @(posedge clk_i);
          hold_off_req <= 1'b0;
        end
        grow = ((i / 40) % 2) == 0;
        send_command(random_command(grow), random_position(), random_item());
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
